>>> src/ssd_pkg.sv
// shared types and constants for the silence stop detector
`timescale 1ns / 1ps
package ssd_pkg;

	localparam int MAX_FRAME_SAMPLES = 1024;

	localparam int SAMPLE_W   = 16;
	localparam int COUNT_W    = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int SUM_W      = SAMPLE_W + $clog2(MAX_FRAME_SAMPLES);
	localparam int ENERGY_W   = 16;
	localparam int ITER_W     = $clog2(SUM_W);
	localparam int THR_W      = 16;
	localparam int QUIET_W    = 16;
	localparam int TICK_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	localparam logic [THR_W-1:0]   THRESHOLD_RST      = THR_W'(50);
	localparam logic [QUIET_W-1:0] SILENT_FRAMES_RST  = QUIET_W'(100);
	localparam logic [TICK_W-1:0]  SILENCE_TIMEOUT_RST = TICK_W'(2000);
	localparam logic [TICK_W-1:0]  MAX_DURATION_RST   = TICK_W'(15000);
	localparam logic [TICK_W-1:0]  DURATION_LIMIT_RST = TICK_W'(0);

	typedef enum logic [1:0] {
		FUNC_START  = 2'd0,
		FUNC_SAMPLE = 2'd1,
		FUNC_TICK   = 2'd2,
		FUNC_NONE   = 2'd3
	} ssd_func_t;

	typedef enum logic [1:0] {
		REASON_NONE    = 2'd0,
		REASON_LIMIT   = 2'd1,
		REASON_MAX     = 2'd2,
		REASON_SILENCE = 2'd3
	} ssd_reason_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD       = 3'd0,
		REG_SILENT_FRAMES   = 3'd1,
		REG_SILENCE_TIMEOUT = 3'd2,
		REG_MAX_DURATION    = 3'd3,
		REG_DURATION_LIMIT  = 3'd4
	} ssd_reg_t;

	typedef enum logic {
		ST_RUN = 1'b0,
		ST_DIV = 1'b1
	} ssd_state_t;

	// classified request as it sits in the queue
	typedef struct packed {
		ssd_func_t             func;
		logic [SAMPLE_W-1:0]   mag;
		logic                  last;
	} ssd_item_t;

	// result word, recording in the lowest bit
	typedef struct packed {
		logic                  loud;
		logic [ENERGY_W-1:0]   energy;
		logic                  frame_done;
		ssd_reason_t           reason;
		logic                  stop_event;
		logic                  recording;
	} ssd_result_t;

	// handshake with the divide unit
	typedef struct packed {
		logic                  start;
		logic [SUM_W-1:0]      dividend;
		logic [COUNT_W-1:0]    divisor;
	} ssd_div_req_t;

endpackage

>>> src/ssd_front.sv
// front part: takes requests, classifies them and forms the sample magnitude
`timescale 1ns / 1ps
module ssd_front import ssd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_func,
	input  logic [SAMPLE_W-1:0] in_sample,
	input  logic                in_last,
	output logic                push,
	output ssd_item_t           push_item,
	input  logic                q_full
);

	logic      valid_s1;
	ssd_item_t item_s1;
	ssd_item_t item_c;

	always_comb begin
		item_c.func = ssd_func_t'(in_func);
		item_c.last = in_last;
		// two's complement magnitude, -32768 maps to 32768
		item_c.mag  = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
	end

	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;
	assign in_ready  = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_c;
		end
	end

endmodule

>>> src/ssd_fifo.sv
// short request queue between front and back
`timescale 1ns / 1ps
module ssd_fifo import ssd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ssd_item_t push_item,
	output logic      full,
	input  logic      pop,
	output ssd_item_t pop_item,
	output logic      empty
);

	ssd_item_t            mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;

	assign full     = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> src/ssd_div.sv
// restoring divider for the frame mean, one quotient bit per cycle
`timescale 1ns / 1ps
module ssd_div import ssd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ssd_div_req_t        req,
	output logic                done,
	output logic [ENERGY_W-1:0] quotient
);

	logic                 run_q;
	logic                 done_q;
	logic [ITER_W-1:0]    iter_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [SUM_W-1:0]     dvd_q;
	logic [COUNT_W-1:0]   dsr_q;
	logic [ENERGY_W-1:0]  quo_q;
	logic [COUNT_W:0]     trial;
	logic [COUNT_W:0]     diff;
	logic                 ge;

	always_comb begin
		trial = {rem_q, dvd_q[SUM_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = (trial >= {1'b0, dsr_q});
	end

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			iter_q <= ITER_W'(SUM_W - 1);
		end else if (run_q) begin
			iter_q <= iter_q - 1'b1;
			if (iter_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// quotient fits the energy width, upper bits shift out as zeros
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			quo_q <= {quo_q[ENERGY_W-2:0], ge};
		end
	end

endmodule

>>> src/ssd_back.sv
// back part: session state, frame decision, stop rules and result register
`timescale 1ns / 1ps
module ssd_back import ssd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  ssd_item_t             item,
	output logic                  pop,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ssd_result_t           out_result
);

	ssd_state_t           state_q, state_d;
	logic                 active_q, active_d;
	logic [SUM_W-1:0]     sum_q, sum_d, sum_n;
	logic [COUNT_W-1:0]   cnt_q, cnt_d, cnt_n;
	logic [QUIET_W-1:0]   quiet_q, quiet_d, quiet_n;
	logic [TICK_W-1:0]    tss_q, tss_d, tss_n;
	logic [TICK_W-1:0]    elapsed_q, elapsed_d, elapsed_n;

	logic [THR_W-1:0]     thr_q;
	logic [QUIET_W-1:0]   req_q;
	logic [TICK_W-1:0]    timeout_q;
	logic [TICK_W-1:0]    max_dur_q;
	logic [TICK_W-1:0]    limit_q;

	logic                 out_valid_q;
	ssd_result_t          out_q;
	ssd_result_t          res;
	logic                 out_load;
	logic                 slot_free;
	logic                 loud;

	ssd_div_req_t         div_req;
	logic                 div_done;
	logic [ENERGY_W-1:0]  div_quo;

	ssd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign out_result = out_q;
	assign slot_free  = !out_valid_q || out_ready;

	always_comb begin
		sum_n     = sum_q + SUM_W'(item.mag);
		cnt_n     = cnt_q + 1'b1;
		quiet_n   = (quiet_q == '1) ? quiet_q : quiet_q + 1'b1;
		tss_n     = (tss_q == '1) ? tss_q : tss_q + 1'b1;
		elapsed_n = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
		loud      = (div_quo > thr_q);
	end

	always_comb begin
		state_d          = state_q;
		active_d         = active_q;
		sum_d            = sum_q;
		cnt_d            = cnt_q;
		quiet_d          = quiet_q;
		tss_d            = tss_q;
		elapsed_d        = elapsed_q;
		pop              = 1'b0;
		out_load         = 1'b0;
		res              = '0;
		div_req.start    = 1'b0;
		div_req.dividend = sum_n;
		div_req.divisor  = cnt_n;
		case (state_q)
			ST_RUN: begin
				if (!q_empty && slot_free) begin
					pop      = 1'b1;
					out_load = 1'b1;
					case (item.func)
						FUNC_START: begin
							if (!active_q) begin
								active_d  = 1'b1;
								sum_d     = '0;
								cnt_d     = '0;
								quiet_d   = '0;
								tss_d     = '0;
								elapsed_d = '0;
							end
							res.recording = 1'b1;
						end
						FUNC_SAMPLE: begin
							if (active_q) begin
								res.recording = 1'b1;
								if (item.last || cnt_n >= COUNT_W'(MAX_FRAME_SAMPLES)) begin
									// result goes out once the mean is known
									sum_d         = '0;
									cnt_d         = '0;
									div_req.start = 1'b1;
									out_load      = 1'b0;
									state_d       = ST_DIV;
								end else begin
									sum_d = sum_n;
									cnt_d = cnt_n;
								end
							end
						end
						FUNC_TICK: begin
							if (active_q) begin
								elapsed_d = elapsed_n;
								tss_d     = tss_n;
								if (limit_q != '0 && elapsed_n >= limit_q) begin
									res.stop_event = 1'b1;
									res.reason     = REASON_LIMIT;
									active_d       = 1'b0;
									sum_d          = '0;
									cnt_d          = '0;
								end else if (elapsed_n >= max_dur_q) begin
									res.stop_event = 1'b1;
									res.reason     = REASON_MAX;
									active_d       = 1'b0;
									sum_d          = '0;
									cnt_d          = '0;
								end else begin
									res.recording = 1'b1;
								end
							end
						end
						default: begin
							res.recording = active_q;
						end
					endcase
				end
			end
			ST_DIV: begin
				if (div_done && slot_free) begin
					out_load       = 1'b1;
					state_d        = ST_RUN;
					res.frame_done = 1'b1;
					res.energy     = div_quo;
					res.loud       = loud;
					res.recording  = 1'b1;
					if (loud) begin
						quiet_d = '0;
						tss_d   = '0;
					end else begin
						quiet_d = quiet_n;
						if (quiet_n >= req_q && tss_q >= timeout_q) begin
							res.stop_event = 1'b1;
							res.reason     = REASON_SILENCE;
							res.recording  = 1'b0;
							active_d       = 1'b0;
						end
					end
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			sum_q     <= '0;
			cnt_q     <= '0;
			quiet_q   <= '0;
			tss_q     <= '0;
			elapsed_q <= '0;
		end else begin
			active_q  <= active_d;
			sum_q     <= sum_d;
			cnt_q     <= cnt_d;
			quiet_q   <= quiet_d;
			tss_q     <= tss_d;
			elapsed_q <= elapsed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THRESHOLD_RST;
			req_q     <= SILENT_FRAMES_RST;
			timeout_q <= SILENCE_TIMEOUT_RST;
			max_dur_q <= MAX_DURATION_RST;
			limit_q   <= DURATION_LIMIT_RST;
		end else if (cfg_valid) begin
			case (ssd_reg_t'(cfg_index))
				REG_THRESHOLD:       thr_q     <= cfg_data[THR_W-1:0];
				REG_SILENT_FRAMES:   req_q     <= cfg_data[QUIET_W-1:0];
				REG_SILENCE_TIMEOUT: timeout_q <= cfg_data[TICK_W-1:0];
				REG_MAX_DURATION:    max_dur_q <= cfg_data[TICK_W-1:0];
				REG_DURATION_LIMIT:  limit_q   <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	// a frame under division belongs to a live session with a cleared accumulator
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> active_q)
		else $error("division pending while not recording");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (sum_q == '0 && cnt_q == '0))
		else $error("accumulator not cleared during division");

	// a full frame is always closed, never left at the bound
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < COUNT_W'(MAX_FRAME_SAMPLES))
		else $error("frame count reached the bound");

	assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (cnt_q == '0 && sum_q == '0))
		else $error("partial frame kept while idle");

endmodule

>>> src/silence_stop_detector.sv
// top level of the silence stop detector
//
//  channel  signals                         payload
//  s_       s_tvalid s_tready               s_tuser func, s_tdata sample, s_tlast last_in_frame
//  m_       m_tvalid m_tready               m_tdata result word
//  cfg_     cfg_valid cfg_ready             cfg_index register, cfg_data value
//
// start, tick and non-closing samples are answered in the back part without the divider
// a frame-closing sample gets its result once the bit-serial divider has the frame mean
// the front keeps taking requests into a 4-deep queue, until it is full, while the back divides or the output stalls
// arst_n clears the session, the counters and the queue and loads the register defaults
`timescale 1ns / 1ps
module silence_stop_detector import ssd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
	input  logic [1:0]            s_tuser,   // [1:0] func
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // [0] recording, [1] stop_event, [3:2] stop_reason,
	                                         // [4] frame_done, [20:5] frame_energy, [21] frame_loud
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic        push;
	ssd_item_t   push_item;
	logic        q_full;
	logic        pop;
	ssd_item_t   pop_item;
	logic        q_empty;
	ssd_result_t result;

	ssd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.in_sample (s_tdata),
		.in_last   (s_tlast),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	ssd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	ssd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.item       (pop_item),
		.pop        (pop),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = {2'b00, result};

endmodule

>>> sim/tb_silence_stop_detector.sv
// self-checking testbench for the silence stop detector
`timescale 1ns / 1ps
module tb_silence_stop_detector import ssd_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 64;
	localparam int ROUND_REQUESTS = 38;
	localparam int LONG_ROUND     = 10;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata = '0;   // [15:0] sample
	logic [1:0]            s_tuser = '0;   // [1:0] func
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [23:0]           m_tdata;        // [0] recording, [1] stop_event, [3:2] stop_reason,
	                                       // [4] frame_done, [20:5] frame_energy, [21] frame_loud
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int src_gap_pct = 38;
	int rx_gap_pct = 60;
	int stalled_cycles = 0;

	silence_stop_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	class detector_scoreboard;
		logic [THR_W-1:0]   threshold    = THRESHOLD_RST;
		logic [QUIET_W-1:0] quiet_needed = SILENT_FRAMES_RST;
		logic [TICK_W-1:0]  quiet_timeout = SILENCE_TIMEOUT_RST;
		logic [TICK_W-1:0]  max_ticks    = MAX_DURATION_RST;
		logic [TICK_W-1:0]  limit_ticks  = DURATION_LIMIT_RST;

		bit                 recording = 1'b0;
		logic [SUM_W-1:0]   level_sum = '0;
		logic [COUNT_W-1:0] frame_len = '0;
		logic [QUIET_W-1:0] quiet_run = '0;
		logic [TICK_W-1:0]  since_sound = '0;
		logic [TICK_W-1:0]  elapsed = '0;

		ssd_result_t        expected_status[$];
		int                 errors = 0;

		function void write_reg(ssd_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_THRESHOLD:       threshold = val[THR_W-1:0];
				REG_SILENT_FRAMES:   quiet_needed = val[QUIET_W-1:0];
				REG_SILENCE_TIMEOUT: quiet_timeout = val[TICK_W-1:0];
				REG_MAX_DURATION:    max_ticks = val[TICK_W-1:0];
				REG_DURATION_LIMIT:  limit_ticks = val[TICK_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_request(ssd_func_t f, logic [SAMPLE_W-1:0] smp, logic lst);
			ssd_result_t r;
			logic [SUM_W-1:0] quot;
			r = '0;
			if (f == FUNC_START && !recording) begin
				recording = 1'b1;
				level_sum = '0;
				frame_len = '0;
				quiet_run = '0;
				since_sound = '0;
				elapsed = '0;
			end else if (f == FUNC_SAMPLE && recording) begin
				level_sum += smp[15] ? SUM_W'(17'h10000 - {1'b0, smp}) : SUM_W'(smp);
				frame_len++;
				if (lst || frame_len >= MAX_FRAME_SAMPLES) begin
					quot = level_sum / frame_len;
					r.frame_done = 1'b1;
					r.energy = quot[ENERGY_W-1:0];
					level_sum = '0;
					frame_len = '0;
					if (r.energy > threshold) begin
						r.loud = 1'b1;
						quiet_run = '0;
						since_sound = '0;
					end else begin
						if (quiet_run != '1)
							quiet_run++;
						if (quiet_run >= quiet_needed && since_sound >= quiet_timeout) begin
							r.stop_event = 1'b1;
							r.reason = REASON_SILENCE;
						end
					end
				end
			end else if (f == FUNC_TICK && recording) begin
				if (elapsed != '1)
					elapsed++;
				if (since_sound != '1)
					since_sound++;
				// duration limit wins over the maximum duration
				if (limit_ticks != '0 && elapsed >= limit_ticks) begin
					r.stop_event = 1'b1;
					r.reason = REASON_LIMIT;
				end else if (elapsed >= max_ticks) begin
					r.stop_event = 1'b1;
					r.reason = REASON_MAX;
				end
			end
			// any stop drops the partial frame too
			if (r.stop_event) begin
				recording = 1'b0;
				level_sum = '0;
				frame_len = '0;
			end
			r.recording = recording;
			expected_status.push_back(r);
		endfunction

		function void flag_error(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t ns: mismatch: %s", $realtime, msg);
		endfunction

		function void check_result(logic [23:0] word);
			ssd_result_t got;
			ssd_result_t want;
			got = word[21:0];
			if (expected_status.size() == 0) begin
				flag_error($sformatf("result %h with no request outstanding", word));
				return;
			end
			want = expected_status.pop_front();
			if (got.recording !== want.recording || got.stop_event !== want.stop_event ||
			    got.reason !== want.reason || got.frame_done !== want.frame_done ||
			    got.energy !== want.energy || got.loud !== want.loud)
				flag_error($sformatf({"expected rec %0b stop %0b reason %0d done %0b ",
					"energy %0d loud %0b, got rec %0b stop %0b reason %0d done %0b ",
					"energy %0d loud %0b"},
					want.recording, want.stop_event, want.reason, want.frame_done,
					want.energy, want.loud, got.recording, got.stop_event, got.reason,
					got.frame_done, got.energy, got.loud));
		endfunction
	endclass

	detector_scoreboard sb;

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_gap_pct);

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);

	// nothing moving on any channel for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready))
			stalled_cycles <= 0;
		else if (stalled_cycles == WATCHDOG_LIMIT) begin
			$display("silence_stop_detector regression: fail");
			$finish;
		end else
			stalled_cycles <= stalled_cycles + 1;
	end

	task automatic send_request(ssd_func_t f, logic [SAMPLE_W-1:0] smp, logic lst);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= smp;
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		sb.note_request(f, smp, lst);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (sb.expected_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_settings(logic [23:0] thr, logic [23:0] quiet_needed,
	                              logic [23:0] timeout, logic [23:0] max_ticks,
	                              logic [23:0] limit_ticks);
		logic [CFG_DATA_W-1:0] vals [5];
		vals[REG_THRESHOLD]       = thr;
		vals[REG_SILENT_FRAMES]   = quiet_needed;
		vals[REG_SILENCE_TIMEOUT] = timeout;
		vals[REG_MAX_DURATION]    = max_ticks;
		vals[REG_DURATION_LIMIT]  = limit_ticks;
		wait_for_results();
		for (int i = REG_THRESHOLD; i <= REG_DURATION_LIMIT; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= ssd_reg_t'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(ssd_reg_t'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [23:0] pick_value(int round, logic [23:0] lo, logic [23:0] hi,
	                                           int typ_lo, int typ_hi);
		int roll;
		roll = $urandom_range(99);
		if (round == 0 || roll < 12)
			return lo;
		if (round == 1 || roll < 24)
			return hi;
		return 24'($urandom_range(typ_lo, typ_hi));
	endfunction

	// mostly well-formed sessions: start, frames of samples with ticks between them
	task automatic run_round(int quota);
		int counted = 0;
		int frame_left = 0;
		int kind = 0;
		int span, mag, pick;
		logic lst;
		logic [SAMPLE_W-1:0] smp;
		while (counted < quota) begin
			if (!sb.recording) begin
				frame_left = 0;
				if ($urandom_range(99) < 80) begin
					send_request(FUNC_START, 16'($urandom), 1'($urandom));
					counted++;
				end else
					send_request(ssd_func_t'($urandom_range(1, 3)), 16'($urandom), 1'($urandom));
			end else begin
				pick = $urandom_range(99);
				if (pick < 3)
					send_request(FUNC_NONE, 16'($urandom), 1'($urandom));
				else if (pick < 5)
					send_request(FUNC_START, 16'($urandom), 1'($urandom));
				else if (pick < 30) begin
					send_request(FUNC_TICK, 16'($urandom), 1'($urandom));
					counted++;
				end else begin
					if (frame_left == 0) begin
						frame_left = ($urandom_range(99) < 4) ? $urandom_range(20, 60)
						                                       : $urandom_range(1, 6);
						kind = $urandom_range(2);
					end
					span = (sb.threshold > 32768) ? 32768 : int'(sb.threshold);
					// full-range noise, a level right at the threshold, or a quiet level
					case (kind)
						0: mag = -1;
						1: mag = span + $urandom_range(2) - 1;
						default: mag = $urandom_range(span);
					endcase
					if (mag > 32768)
						mag = 32768;
					if (kind == 1 && mag < 0)
						mag = 0;
					if (mag < 0)
						smp = 16'($urandom);
					else if ($urandom_range(1))
						smp = 16'(-mag);
					else
						smp = 16'((mag > 32767) ? 32767 : mag);
					frame_left--;
					lst = (frame_left == 0);
					// now and then a frame ends early or runs into the next one
					if ($urandom_range(99) < 2) begin
						lst = ~lst;
						if (lst)
							frame_left = 0;
					end
					send_request(FUNC_SAMPLE, smp, lst);
					counted++;
				end
			end
		end
	endtask

	initial begin
		logic [23:0] thr, quiet_needed, timeout, max_ticks, limit_ticks;
		int round;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: threshold 50, 100 quiet frames needed
		send_request(FUNC_TICK, 16'h1234, 1'b1);      // tick while idle
		send_request(FUNC_SAMPLE, 16'h8000, 1'b1);    // sample while idle
		send_request(FUNC_NONE, 16'hFFFF, 1'b1);
		send_request(FUNC_START, 16'h0000, 1'b0);
		send_request(FUNC_START, 16'hFFFF, 1'b1);     // start while recording
		send_request(FUNC_SAMPLE, 16'h7FFF, 1'b1);
		send_request(FUNC_SAMPLE, 16'h8000, 1'b1);    // largest magnitude
		send_request(FUNC_SAMPLE, 16'h0000, 1'b0);
		send_request(FUNC_SAMPLE, 16'hFFFF, 1'b1);    // mean of 1/2 floors to zero
		send_request(FUNC_NONE, 16'h5555, 1'b0);      // unused func while recording
		send_request(FUNC_TICK, 16'hAAAA, 1'b0);

		// zero threshold and zero maximum duration
		write_settings(24'd0, 24'd1, 24'd0, 24'd0, 24'd0);
		send_request(FUNC_SAMPLE, 16'h0000, 1'b1);    // silent frame stops at once
		send_request(FUNC_START, 16'h0000, 1'b0);
		send_request(FUNC_SAMPLE, 16'hFFFF, 1'b1);    // energy one is loud
		send_request(FUNC_TICK, 16'h0000, 1'b0);      // first tick stops

		// limit and maximum hit on the same tick, then silence after a timeout
		write_settings(24'd50, 24'd2, 24'd1, 24'd2, 24'd2);
		send_request(FUNC_START, 16'h0000, 1'b0);
		send_request(FUNC_TICK, 16'h0000, 1'b0);
		send_request(FUNC_TICK, 16'h0000, 1'b0);
		send_request(FUNC_START, 16'h0000, 1'b0);
		send_request(FUNC_SAMPLE, 16'h0000, 1'b1);
		send_request(FUNC_TICK, 16'h0000, 1'b0);
		send_request(FUNC_SAMPLE, 16'h0003, 1'b1);

		for (int mode = 0; mode < 3; mode++) begin
			src_gap_pct = (mode == 0) ? 38 : (mode == 1) ? 60 : 0;
			rx_gap_pct = (mode == 0) ? 60 : (mode == 1) ? 38 : 0;
			for (int r = 0; r < 5; r++) begin
				round = mode * 5 + r;
				thr = pick_value(round, 24'd1, 24'd32768, 20, 3000);
				if (round == 1)
					thr = 24'hFFFF;
				quiet_needed = pick_value(round, 24'd1, 24'hFFFF, 1, 6);
				timeout = pick_value(round, 24'd0, 24'hFFFFFF, 0, 30);
				max_ticks = pick_value(round, 24'd1, 24'hFFFFFF, 10, 80);
				limit_ticks = pick_value(round, 24'd0, 24'hFFFFFF, 0, 60);
				if ($urandom_range(1))
					limit_ticks = '0;
				write_settings(thr, quiet_needed, timeout, max_ticks, limit_ticks);
				// one frame that runs into the frame-size bound at full scale
				if (round == LONG_ROUND) begin
					if (sb.recording)
						send_request(FUNC_SAMPLE, 16'h0001, 1'b1);
					if (!sb.recording)
						send_request(FUNC_START, 16'h0000, 1'b0);
					repeat (MAX_FRAME_SAMPLES)
						send_request(FUNC_SAMPLE, 16'h8000, 1'b0);
				end
				run_round(ROUND_REQUESTS);
			end
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("silence_stop_detector regression: pass");
		else
			$display("silence_stop_detector regression: fail");
		$finish;
	end

endmodule
